// File: rtl/assert_macros.svh
// Assertion macros for the top level, the one RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// File: rtl/pse_pkg.sv
// Package with the types, constants and codes of the PPPoE session encap/decap block.
package pse_pkg;

    localparam int HDR_LEN = 22;
    localparam int ETH_LEN = 14;
    localparam int MAC_LEN = 12;
    localparam int CNT_W   = $clog2(HDR_LEN + 1);
    localparam int POS_W   = $clog2(HDR_LEN + 1);
    localparam int Q_DEPTH = 4;

    localparam logic [15:0] ET_PPPOE   = 16'h8864;
    localparam logic [15:0] ET_IPV4    = 16'h0800;
    localparam logic [15:0] ET_IPV6    = 16'h86DD;
    localparam logic [15:0] PPP_IPV4   = 16'h0021;
    localparam logic [15:0] PPP_IPV6   = 16'h0057;
    localparam logic [7:0]  VER_TYPE   = 8'h11;
    localparam logic [7:0]  SESS_CODE  = 8'h00;
    localparam logic [15:0] MAC_LEN_16 = 16'(MAC_LEN);

    localparam logic CFG_SESSION = 1'b0;
    localparam logic CFG_ENCAP   = 1'b1;

    typedef enum logic [1:0] {
        MODE_ETH,
        MODE_SESS,
        MODE_PASS
    } t_mode;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic        in_last;
        logic [15:0] frame_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       frame_dropped;
    } t_out_item;

    typedef struct packed {
        logic                         drop;
        logic                         last;
        logic [CNT_W-1:0]             count;
        logic [HDR_LEN-1:0][7:0]      bytes;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: rtl/pse_front.sv
// Front end: header buffering, frame classification and command generation.
module pse_front import pse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_push,
    input  t_in_item    i_in,
    input  t_q_stat     i_stat,
    output logic        o_cmd_push,
    output t_cmd        o_cmd
);

    t_mode                   r_mode, n_mode;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic [7:0]              r_store [HDR_LEN];
    logic [15:0]             r_session;
    logic                    r_encap;
    logic [HDR_LEN-1:0][7:0] hdr;
    logic [15:0]             et, pp, enc_pp, dec_et, plen;
    logic                    accept;

    assign accept = i_push && !i_stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_ETH;
            r_pos     <= '0;
            r_session <= '0;
            r_encap   <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            if (i_cfg_we && i_cfg_idx == CFG_SESSION) begin
                r_session <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == CFG_ENCAP) begin
                r_encap <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_mode != MODE_PASS && r_pos < POS_W'(HDR_LEN)) begin
            r_store[r_pos] <= i_in.in_byte;
        end
    end

    always_comb begin
        for (int i = 0; i < HDR_LEN; i++) begin
            hdr[i] = (POS_W'(i) == r_pos) ? i_in.in_byte : r_store[i];
        end
        et     = {r_store[12], i_in.in_byte};
        pp     = {r_store[20], i_in.in_byte};
        enc_pp = (et == ET_IPV4) ? PPP_IPV4 : PPP_IPV6;
        dec_et = (pp == PPP_IPV4) ? ET_IPV4 : ET_IPV6;
        plen   = i_in.frame_length - MAC_LEN_16;
    end

    always_comb begin
        n_mode      = r_mode;
        n_pos       = r_pos;
        o_cmd_push  = 1'b0;
        o_cmd.drop  = 1'b0;
        o_cmd.last  = i_in.in_last;
        o_cmd.count = CNT_W'(1);
        o_cmd.bytes = hdr;
        if (accept) begin
            unique case (r_mode)
                MODE_PASS: begin
                    o_cmd_push     = 1'b1;
                    o_cmd.bytes[0] = i_in.in_byte;
                    if (i_in.in_last) begin
                        n_mode = MODE_ETH;
                        n_pos  = '0;
                    end
                end
                MODE_ETH, MODE_SESS: begin
                    if (r_pos >= POS_W'(HDR_LEN)) begin
                        n_mode = MODE_ETH;
                        n_pos  = '0;
                    end else if ((r_mode == MODE_ETH && r_pos < POS_W'(ETH_LEN - 1)) ||
                                 (r_mode == MODE_SESS && r_pos < POS_W'(HDR_LEN - 1))) begin
                        n_pos = r_pos + 1'b1;
                        if (i_in.in_last) begin
                            o_cmd_push  = 1'b1;
                            o_cmd.drop  = 1'b1;
                            o_cmd.last  = 1'b1;
                            o_cmd.bytes = '0;
                            n_mode      = MODE_ETH;
                            n_pos       = '0;
                        end
                    end else if (r_mode == MODE_ETH && r_pos != POS_W'(ETH_LEN - 1)) begin
                        n_mode = MODE_ETH;
                        n_pos  = '0;
                    end else if (r_mode == MODE_ETH && !r_encap && et == ET_PPPOE) begin
                        n_pos = r_pos + 1'b1;
                        if (i_in.in_last) begin
                            o_cmd_push  = 1'b1;
                            o_cmd.drop  = 1'b1;
                            o_cmd.last  = 1'b1;
                            o_cmd.bytes = '0;
                            n_mode      = MODE_ETH;
                            n_pos       = '0;
                        end else begin
                            n_mode = MODE_SESS;
                        end
                    end else begin
                        o_cmd_push = 1'b1;
                        n_mode     = i_in.in_last ? MODE_ETH : MODE_PASS;
                        n_pos      = i_in.in_last ? '0 : r_pos + 1'b1;
                        if (r_mode == MODE_ETH) begin
                            o_cmd.count = CNT_W'(ETH_LEN);
                            if (r_encap && (et == ET_IPV4 || et == ET_IPV6)) begin
                                o_cmd.count     = CNT_W'(HDR_LEN);
                                o_cmd.bytes[12] = ET_PPPOE[15:8];
                                o_cmd.bytes[13] = ET_PPPOE[7:0];
                                o_cmd.bytes[14] = VER_TYPE;
                                o_cmd.bytes[15] = SESS_CODE;
                                o_cmd.bytes[16] = r_session[15:8];
                                o_cmd.bytes[17] = r_session[7:0];
                                o_cmd.bytes[18] = plen[15:8];
                                o_cmd.bytes[19] = plen[7:0];
                                o_cmd.bytes[20] = enc_pp[15:8];
                                o_cmd.bytes[21] = enc_pp[7:0];
                            end
                        end else if (pp == PPP_IPV4 || pp == PPP_IPV6) begin
                            o_cmd.count     = CNT_W'(ETH_LEN);
                            o_cmd.bytes[12] = dec_et[15:8];
                            o_cmd.bytes[13] = dec_et[7:0];
                        end else begin
                            o_cmd.count = CNT_W'(HDR_LEN);
                        end
                    end
                end
                default: begin
                    n_mode = MODE_ETH;
                    n_pos  = '0;
                end
            endcase
        end
    end

endmodule

// File: rtl/pse_fifo.sv
// Short command queue between the front end and the output sequencer.
module pse_fifo import pse_pkg::*; #(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_data,
    input  logic    i_pop,
    output t_cmd    o_data,
    output t_q_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          push_ok, pop_ok;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign push_ok      = i_push && !o_stat.full;
    assign pop_ok       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/pse_back.sv
// Output sequencer: plays each queued command out as one result byte per request.
module pse_back import pse_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_q_stat   i_stat,
    input  logic      i_pop,
    output t_out_item o_out,
    output logic      o_empty,
    output logic      o_q_pop
);

    logic [CNT_W-1:0] r_idx;
    logic             final_byte;

    assign final_byte          = (r_idx == i_cmd.count - 1'b1);
    assign o_empty             = i_stat.empty;
    assign o_q_pop             = i_pop && !i_stat.empty && final_byte;
    assign o_out.out_byte      = i_cmd.bytes[r_idx];
    assign o_out.out_last      = i_cmd.last && final_byte;
    assign o_out.frame_dropped = i_cmd.drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_pop && !i_stat.empty) begin
            r_idx <= final_byte ? '0 : r_idx + 1'b1;
        end
    end

endmodule

// File: rtl/pppoe_session_encap_decap.sv
// Top level of the PPPoE session encapsulation and decapsulation block.
// Frames enter one byte per request on a queue-style port: a byte is taken at
// a rising edge with push high and full low. Results leave the same way: the
// oldest result shows on o_out while empty is low and is taken with pop.
// Bytes of the Ethernet header are held until the frame is classified, then
// the rewritten header leaves as a burst of up to 22 results, one per cycle while
// pop is held high. Later bytes stream through, one byte per cycle while pop is high.
// A short frame yields a single result with frame_dropped set.
// The front end takes one byte every cycle as long as the command queue
// (QUEUE_DEPTH entries) has room; a header burst holds its queue entry until
// all of its bytes are popped, so the queue sets how far input may run ahead.
// When the receiver stalls, results wait and full rises once the queue fills.
// Session number and mode are written on the configuration port and sampled
// at the fourteenth byte of each frame. Synchronous reset empties the queue,
// clears both registers and restarts header buffering; the header store itself
// is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module pppoe_session_encap_decap import pse_pkg::*; #(
    parameter int QUEUE_DEPTH = Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out
);

    t_q_stat q_stat;
    t_cmd    cmd_in, cmd_head;
    logic    cmd_push, q_pop;

    assign full = q_stat.full;

    pse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_in       (i_in),
        .i_stat     (q_stat),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    pse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (q_pop),
        .o_data  (cmd_head),
        .o_stat  (q_stat)
    );

    pse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_head),
        .i_stat  (q_stat),
        .i_pop   (pop),
        .o_out   (o_out),
        .o_empty (empty),
        .o_q_pop (q_pop)
    );

    `ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> empty && !full)
    `ASSERT_CLK(a_drop_is_final, i_clk, i_rst_n,
        (!empty && o_out.frame_dropped) |-> (o_out.out_last && o_out.out_byte == 8'h00))
    `ASSERT_CLK(a_last_frees_entry, i_clk, i_rst_n,
        (!empty && pop && o_out.out_last) |-> q_pop)

endmodule
